// File: design/svmdc_pkg.sv
// ----------------------------------------------------------------------------
// svmdc_pkg
// Shared constants for the SVPWM duty generator with zero-sequence injection.
// ----------------------------------------------------------------------------
`default_nettype none

package svmdc_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Intermediate duty unit is 2^-49.
  localparam int unsigned UNIT_SHIFT = 49;
  localparam int unsigned DW         = 52;          // stage duty width
  localparam int unsigned SW         = DW + 1;      // shifted duty width

  localparam logic [31:0] INV_SQRT3_Q32  = 32'd2479700525;
  localparam logic [31:0] SQRT3_DIV2_Q32 = 32'd3719550787;

  localparam logic signed [DW-1:0]   HALF_U = DW'(64'sd1 <<< (UNIT_SHIFT - 1));
  localparam logic signed [DW+1:0]   ONE_U  = (DW+2)'(64'sd1 <<< UNIT_SHIFT);

  localparam int unsigned DATA_W = 16;
  localparam int unsigned ADDR_W = 3;

  // Strategy codes
  localparam logic [1:0] STRAT_SIN = 2'd0;
  localparam logic [1:0] STRAT_TB  = 2'd1;
  localparam logic [1:0] STRAT_MID = 2'd2;

  // Register word index
  localparam logic REG_STRATEGY = 1'b0;

endpackage

`default_nettype wire

// File: design/svm_duty_cycle_zero_sequence.sv
// Throughput: one request per cycle; a stalled output holds the pipeline in place.
// Stages: multiply, phase sums, min/max, zero-sequence shift, round and saturate.
// Reset: asynchronous active low; clears the stage valid bits and the strategy to
// sinusoidal. No clearing pass.
// ----------------------------------------------------------------------------
// svm_duty_cycle_zero_sequence
// Inverse Clarke to three phase duties with min/max zero-sequence injection.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_duty_cycle_zero_sequence #(
  parameter int unsigned SAMPLE_BITS = svmdc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [svmdc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,  // v_alpha, v_beta
  // output stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [63:0]                   m_axis_tdata   // duty_a, duty_b, duty_c,
                                                            // max_amplitude
);

  localparam int unsigned DW    = svmdc_pkg::DW;
  localparam int unsigned SW    = svmdc_pkg::SW;
  localparam int unsigned OW    = svmdc_pkg::DATA_W;
  localparam int unsigned SHIFT = svmdc_pkg::UNIT_SHIFT - SAMPLE_BITS;
  localparam logic [SW-1:0] RND = SW'(64'd1 << (SHIFT - 1));
  localparam logic [SW-1:0] FS  = SW'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [63:0] AMP_RAW =
      (({32'd0, svmdc_pkg::SQRT3_DIV2_Q32} << 1) + (64'd1 << (32 - SAMPLE_BITS)))
      >> (33 - SAMPLE_BITS);
  localparam logic [63:0] FS64    = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam logic [OW-1:0] AMP_SIN  = (AMP_RAW > FS64) ? FS64[OW-1:0] : AMP_RAW[OW-1:0];
  localparam logic [OW-1:0] AMP_CLMP = FS64[OW-1:0];

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [1:0] strategy_q, strategy_d;
  logic       cfg_wr;
  logic       addr_hit;

  assign pready   = 1'b1;
  assign addr_hit = (paddr[2] == svmdc_pkg::REG_STRATEGY);
  assign cfg_wr   = psel && penable && pwrite && pready && addr_hit;

  always_comb begin
    strategy_d = strategy_q;
    if (cfg_wr) begin
      strategy_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q <= svmdc_pkg::STRAT_SIN;
    end else begin
      strategy_q <= strategy_d;
    end
  end

  assign prdata = addr_hit ? {30'd0, strategy_q} : 32'd0;

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic [5:1] v_q, v_d;
  logic [6:1] rdy;

  always_comb begin
    rdy[6] = m_axis_tready;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[1] = rdy[1] ? s_axis_tvalid : v_q[1];
    for (int k = 2; k <= 5; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = rdy[1];
  assign m_axis_tvalid = v_q[5];

  // --------------------------------------------------------------------------
  // Stage 1: alpha / sqrt3
  // --------------------------------------------------------------------------
  logic signed [48:0] ak_q, ak_d;
  logic signed [15:0] vb_q;

  assign ak_d = $signed(s_axis_tdata[15:0]) * $signed({1'b0, svmdc_pkg::INV_SQRT3_Q32});

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      ak_q <= ak_d;
      vb_q <= $signed(s_axis_tdata[31:16]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: phase duties
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] ak_x, bt_x;
  logic signed [DW-1:0] d2_d [3];
  logic signed [DW-1:0] d2_q [3];

  always_comb begin
    ak_x     = DW'(ak_q);
    bt_x     = DW'(vb_q) <<< 33;
    d2_d[0]  = (ak_x <<< 2) + svmdc_pkg::HALF_U;
    d2_d[1]  = -(ak_x <<< 1) + bt_x + svmdc_pkg::HALF_U;
    d2_d[2]  = -(ak_x <<< 1) - bt_x + svmdc_pkg::HALF_U;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      d2_q <= d2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: min / max
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] mn_d, mx_d, mn_q, mx_q;
  logic signed [DW-1:0] d3_q [3];

  always_comb begin
    mn_d = d2_q[0];
    mx_d = d2_q[0];
    for (int i = 1; i < 3; i++) begin
      if (d2_q[i] < mn_d) begin
        mn_d = d2_q[i];
      end
      if (d2_q[i] > mx_d) begin
        mx_d = d2_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      d3_q <= d2_q;
      mn_q <= mn_d;
      mx_q <= mx_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: zero-sequence shift
  // --------------------------------------------------------------------------
  logic signed [DW+1:0] top, mn_w, mx_w, mid;
  logic signed [SW-1:0] sh_d, sh_q;
  logic signed [DW-1:0] d4_q [3];

  always_comb begin
    mn_w = (DW+2)'(mn_q);
    mx_w = (DW+2)'(mx_q);
    top  = svmdc_pkg::ONE_U - mx_w;
    mid  = (svmdc_pkg::ONE_U - mn_w - mx_w) >>> 1;   // always even, exact
    case (strategy_q)
      svmdc_pkg::STRAT_TB: begin
        sh_d = (top < mn_w) ? SW'(top) : SW'(-mn_w);
      end
      svmdc_pkg::STRAT_MID: begin
        sh_d = SW'(mid);
      end
      default: begin
        sh_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      d4_q <= d3_q;
      sh_q <= sh_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: shift, round, saturate
  // --------------------------------------------------------------------------
  function automatic logic [OW-1:0] to_out(input logic signed [DW-1:0] d,
                                           input logic signed [SW-1:0] sh);
    logic signed [SW-1:0] sum;
    logic        [SW-1:0] r;
    sum = SW'(d) + sh;
    r   = (SW'(sum) + RND) >> SHIFT;
    if (sum <= 0) begin
      return '0;
    end else if (r > FS) begin
      return FS[OW-1:0];
    end
    return r[OW-1:0];
  endfunction

  logic [OW-1:0] duty_a_q, duty_b_q, duty_c_q, amp_q, amp_d;

  assign amp_d = (strategy_q == svmdc_pkg::STRAT_TB || strategy_q == svmdc_pkg::STRAT_MID)
               ? AMP_CLMP : AMP_SIN;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      duty_a_q <= to_out(d4_q[0], sh_q);
      duty_b_q <= to_out(d4_q[1], sh_q);
      duty_c_q <= to_out(d4_q[2], sh_q);
      amp_q    <= amp_d;
    end
  end

  assign m_axis_tdata = {amp_q, duty_c_q, duty_b_q, duty_a_q};

`ifndef SYNTHESIS
  logic signed [DW+1:0] d3_sum;
  assign d3_sum = (DW+2)'(d3_q[0]) + (DW+2)'(d3_q[1]) + (DW+2)'(d3_q[2]);

  a_phase_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> d3_sum == 3 * (DW+2)'(svmdc_pkg::HALF_U))
    else $error("phase duties do not sum to three halves");

  a_minmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (mn_q <= mx_q) && (mn_q <= d3_q[1]) && (mx_q >= d3_q[2]))
    else $error("min/max out of order");

  a_amp_sin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && strategy_q == svmdc_pkg::STRAT_SIN) |-> amp_q == AMP_SIN)
    else $error("sinusoidal amplitude wrong");

  a_amp_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (strategy_q == svmdc_pkg::STRAT_TB ||
                       strategy_q == svmdc_pkg::STRAT_MID)) |-> amp_q == AMP_CLMP)
    else $error("clamp amplitude wrong");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && !rdy[4]) |=> (v_q[4] && $stable(sh_q)))
    else $error("stage four lost data under stall");
`endif

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SVPWM duty generator with zero-sequence shift.
// A directed table covers the axis extremes, the clamp tie and both clamp
// directions, saturation at both ends and every strategy code. Random vectors
// follow in six phases over the strategy settings. Each request is predicted in
// 2^-49 fixed point or taken from the table, and compared field by field with
// the result stream while the source bursts and the sink stalls at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned       ADDR_W        = svmdc_pkg::ADDR_W;
  localparam logic [1:0]        STRAT_SPARE   = 2'd3;
  localparam logic [ADDR_W-1:0] STRATEGY_ADDR = ADDR_W'(4 * svmdc_pkg::REG_STRATEGY);

  localparam longint RECIP_SQRT3 = 64'sd2479700525;     // 1/sqrt3 in 2^-32
  localparam longint HALF_DUTY   = 64'sd1 <<< 48;       // 1/2 in 2^-49
  localparam longint FULL_DUTY   = 64'sd1 <<< 49;       // 1 in 2^-49
  localparam logic [15:0] SIN_AMP =
    16'(((64'd3719550787 << 1) + (64'd1 << 16)) >> 17);
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [15:0] max_amp;
    logic [15:0] duty_c;
    logic [15:0] duty_b;
    logic [15:0] duty_a;
  } duty_set_t;

  typedef struct {
    logic [1:0]         strat;
    logic signed [15:0] va;
    logic signed [15:0] vb;
    bit                 typed;
    duty_set_t          duties;
  } vector_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // v_alpha, v_beta
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // duty_a, duty_b, duty_c, max_amplitude

  duty_set_t   expected_duties[$];
  vector_row_t vector_table[$];
  logic [1:0]  strategy_q = svmdc_pkg::STRAT_SIN;
  int          mismatch_count = 0;
  int          burst_left = 0;

  svm_duty_cycle_zero_sequence dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #200000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [15:0] quantize(longint d);
    longint r;
    if (d <= 0) begin
      return 16'd0;
    end
    r = (d + (64'sd1 <<< 32)) >>> 33;
    return (r > 65535) ? 16'hFFFF : 16'(r);
  endfunction

  function automatic duty_set_t predict_duties(logic signed [15:0] va,
                                               logic signed [15:0] vb,
                                               logic [1:0] strat);
    longint    alpha_k;
    longint    beta_h;
    longint    ph[3];
    longint    lo;
    longint    hi;
    longint    top;
    longint    shift;
    duty_set_t r;
    alpha_k = longint'(va) * RECIP_SQRT3;
    beta_h  = longint'(vb) <<< 33;
    ph[0] = alpha_k * 4 + HALF_DUTY;
    ph[1] = -(alpha_k * 2) + beta_h + HALF_DUTY;
    ph[2] = -(alpha_k * 2) - beta_h + HALF_DUTY;
    lo = ph[0];
    hi = ph[0];
    for (int i = 1; i < 3; i++) begin
      if (ph[i] < lo) lo = ph[i];
      if (ph[i] > hi) hi = ph[i];
    end
    case (strat)
      svmdc_pkg::STRAT_TB: begin
        top   = FULL_DUTY - hi;
        shift = (top < lo) ? top : -lo;
      end
      svmdc_pkg::STRAT_MID: shift = (FULL_DUTY - lo - hi) / 2;
      default:   shift = 0;
    endcase
    r.duty_a  = quantize(ph[0] + shift);
    r.duty_b  = quantize(ph[1] + shift);
    r.duty_c  = quantize(ph[2] + shift);
    r.max_amp = (strat == svmdc_pkg::STRAT_TB || strat == svmdc_pkg::STRAT_MID)
              ? 16'hFFFF : SIN_AMP;
    return r;
  endfunction

  function automatic duty_set_t duties(int a, int b, int c, int m);
    return '{max_amp: 16'(m), duty_c: 16'(c), duty_b: 16'(b), duty_a: 16'(a)};
  endfunction

  function automatic logic signed [15:0] random_component();
    logic signed [15:0] extremes[6] = '{-16'sd32768, 16'sd32767, 16'sd0,
                                        16'sd1, -16'sd1, 16'sd16384};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom);
      5, 6, 7:       return 16'($urandom) >>> $urandom_range(1, 4);
      default:       return extremes[$urandom_range(0, 5)];
    endcase
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    duty_set_t got;
    duty_set_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_duties.size() == 0) begin
        $error("result with no request outstanding: %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_duties.pop_front();
        check_field("duty_a", want.duty_a, got.duty_a);
        check_field("duty_b", want.duty_b, got.duty_b);
        check_field("duty_c", want.duty_c, got.duty_c);
        check_field("max_amplitude", want.max_amp, got.max_amp);
      end
    end
  end

  // sink stall pattern: a randomly chosen mode drives m_axis_tready
  int sink_mode = 0;
  int sink_cycle = 0;
  always @(posedge clk_i) begin
    if (sink_cycle % 64 == 0) sink_mode = $urandom_range(0, 4);
    sink_cycle++;
    case (sink_mode)
      0, 1: m_axis_tready <= 1'b1;
      2:    m_axis_tready <= ($urandom_range(0, 1) == 0);
      3:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (sink_cycle % 7 < 3);
    endcase
  end

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_check(logic [ADDR_W-1:0] addr, logic [31:0] want);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      $error("strategy readback: expected %0d, got %0d", want, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_strategy(logic [1:0] strat);
    apb_write(STRATEGY_ADDR, {30'd0, strat});
    strategy_q = strat;
    apb_check(STRATEGY_ADDR, {30'd0, strat});
  endtask

  task automatic wait_results(int extra);
    s_axis_tvalid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic send_vector(logic signed [15:0] va, logic signed [15:0] vb,
                             bit typed, duty_set_t typed_duties);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {vb, va};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_duties.push_back(typed ? typed_duties : predict_duties(va, vb, strategy_q));
  endtask

  initial begin
    logic [1:0] phase_strat[6] = '{svmdc_pkg::STRAT_TB, svmdc_pkg::STRAT_MID,
                                   svmdc_pkg::STRAT_SIN, STRAT_SPARE,
                                   svmdc_pkg::STRAT_MID, svmdc_pkg::STRAT_TB};
    duty_set_t none = '0;

    // sinusoidal: zero vector, beta at negative full scale saturates phase C
    vector_table.push_back('{svmdc_pkg::STRAT_SIN, 16'sd0, 16'sd0, 1'b1,
                             duties(32768, 32768, 32768, 56756)});
    vector_table.push_back('{svmdc_pkg::STRAT_SIN, 16'sd0, -16'sd32768, 1'b1,
                             duties(32768, 0, 65535, 56756)});
    vector_table.push_back('{svmdc_pkg::STRAT_SIN, 16'sd32767, 16'sd0, 1'b0, none});
    vector_table.push_back('{svmdc_pkg::STRAT_SIN, -16'sd32768, 16'sd0, 1'b0, none});
    vector_table.push_back('{svmdc_pkg::STRAT_SIN, 16'sd32767, 16'sd32767, 1'b0, none});
    vector_table.push_back('{svmdc_pkg::STRAT_SIN, -16'sd32768, -16'sd32768, 1'b0, none});
    // top/bottom clamp: ties subtract the bottom
    vector_table.push_back('{svmdc_pkg::STRAT_TB, 16'sd0, 16'sd0, 1'b1,
                             duties(0, 0, 0, 65535)});
    vector_table.push_back('{svmdc_pkg::STRAT_TB, 16'sd0, -16'sd32768, 1'b1,
                             duties(32768, 0, 65535, 65535)});
    vector_table.push_back('{svmdc_pkg::STRAT_TB, 16'sd16384, 16'sd0, 1'b0, none});
    vector_table.push_back('{svmdc_pkg::STRAT_TB, -16'sd16384, 16'sd0, 1'b0, none});
    vector_table.push_back('{svmdc_pkg::STRAT_TB, 16'sd32767, -16'sd32768, 1'b0, none});
    vector_table.push_back('{svmdc_pkg::STRAT_TB, -16'sd32768, 16'sd32767, 1'b0, none});
    // midpoint clamp
    vector_table.push_back('{svmdc_pkg::STRAT_MID, 16'sd0, 16'sd0, 1'b1,
                             duties(32768, 32768, 32768, 65535)});
    vector_table.push_back('{svmdc_pkg::STRAT_MID, 16'sd0, -16'sd32768, 1'b1,
                             duties(32768, 0, 65535, 65535)});
    vector_table.push_back('{svmdc_pkg::STRAT_MID, 16'sd32767, 16'sd32767, 1'b0, none});
    vector_table.push_back('{svmdc_pkg::STRAT_MID, -16'sd32768, -16'sd32768, 1'b0, none});
    vector_table.push_back('{svmdc_pkg::STRAT_MID, 16'sd12345, -16'sd23456, 1'b0, none});
    // unused code behaves as sinusoidal
    vector_table.push_back('{STRAT_SPARE, 16'sd0, 16'sd0, 1'b1,
                             duties(32768, 32768, 32768, 56756)});
    vector_table.push_back('{STRAT_SPARE, -16'sd32768, 16'sd32767, 1'b0, none});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_check(STRATEGY_ADDR, {30'd0, svmdc_pkg::STRAT_SIN});

    foreach (vector_table[i]) begin
      if (vector_table[i].strat != strategy_q) begin
        wait_results(DRAIN_CYCLES);
        set_strategy(vector_table[i].strat);
      end
      send_vector(vector_table[i].va, vector_table[i].vb,
                  vector_table[i].typed, vector_table[i].duties);
    end

    foreach (phase_strat[p]) begin
      wait_results(DRAIN_CYCLES);
      set_strategy(phase_strat[p]);
      for (int n = 0; n < 75; n++) begin
        if (p == 0 && n == 40) wait_results(1);
        send_vector(random_component(), random_component(), 1'b0, none);
      end
    end

    wait_results(DRAIN_CYCLES);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
design/svmdc_pkg.sv
design/svm_duty_cycle_zero_sequence.sv
sim/tb.sv
